// ===== design/sti_pkg.sv =====
// Shared constants for the segment versus triangle intersection block.
// No dependencies.
package sti_pkg;

  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Z   = 3'd5;

endpackage

// ===== design/sti_front.sv =====
// Edge vectors and the two cross products, two register stages.
// Depends on nothing beyond its parameters.
module sti_front #(
  parameter int COORD_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_BITS-1:0]   ax, ay, az, bx, by, bz, cx, cy, cz,
  input  logic signed [COORD_BITS-1:0]   sx, sy, sz, ex, ey, ez,
  output logic                           valid,
  output logic signed [COORD_BITS:0]     ab_x, ab_y, ab_z, ac_x, ac_y, ac_z,
  output logic signed [2*COORD_BITS+2:0] n_x, n_y, n_z, e_x, e_y, e_z
);
  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D + 1;

  function automatic logic signed [P-1:0] crs(input logic signed [D-1:0] p0, p1, p2, p3);
    logic signed [2*D-1:0] m0, m1;
    m0 = p0 * p1;
    m1 = p2 * p3;
    return P'(m0) - P'(m1);
  endfunction

  logic                valid1_r, valid2_r;
  logic signed [D-1:0] abx_r, aby_r, abz_r, acx_r, acy_r, acz_r;
  logic signed [D-1:0] qpx_r, qpy_r, qpz_r, apx_r, apy_r, apz_r;
  logic signed [D-1:0] abx2_r, aby2_r, abz2_r, acx2_r, acy2_r, acz2_r;
  logic signed [P-1:0] nx_r, ny_r, nz_r, ex_r, ey_r, ez_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx_r <= D'(bx) - D'(ax);
      aby_r <= D'(by) - D'(ay);
      abz_r <= D'(bz) - D'(az);
      acx_r <= D'(cx) - D'(ax);
      acy_r <= D'(cy) - D'(ay);
      acz_r <= D'(cz) - D'(az);
      qpx_r <= D'(sx) - D'(ex);
      qpy_r <= D'(sy) - D'(ey);
      qpz_r <= D'(sz) - D'(ez);
      apx_r <= D'(sx) - D'(ax);
      apy_r <= D'(sy) - D'(ay);
      apz_r <= D'(sz) - D'(az);
      abx2_r <= abx_r; aby2_r <= aby_r; abz2_r <= abz_r;
      acx2_r <= acx_r; acy2_r <= acy_r; acz2_r <= acz_r;
      nx_r <= crs(aby_r, acz_r, abz_r, acy_r);
      ny_r <= crs(abz_r, acx_r, abx_r, acz_r);
      nz_r <= crs(abx_r, acy_r, aby_r, acx_r);
      ex_r <= crs(qpy_r, apz_r, qpz_r, apy_r);
      ey_r <= crs(qpz_r, apx_r, qpx_r, apz_r);
      ez_r <= crs(qpx_r, apy_r, qpy_r, apx_r);
    end
  end

  assign valid = valid2_r;
  assign ab_x = abx2_r; assign ab_y = aby2_r; assign ab_z = abz2_r;
  assign ac_x = acx2_r; assign ac_y = acy2_r; assign ac_z = acz2_r;
  assign n_x = nx_r; assign n_y = ny_r; assign n_z = nz_r;
  assign e_x = ex_r; assign e_y = ey_r; assign e_z = ez_r;
endmodule

// ===== design/sti_dot.sv =====
// Dot products d, t, v and w, then the hit tests, two register stages.
// Depends on nothing beyond its parameters.
module sti_dot #(
  parameter int COORD_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_BITS:0]     ab_x, ab_y, ab_z, ac_x, ac_y, ac_z,
  input  logic signed [COORD_BITS:0]     qp_x, qp_y, qp_z, ap_x, ap_y, ap_z,
  input  logic signed [2*COORD_BITS+2:0] n_x, n_y, n_z, e_x, e_y, e_z,
  output logic                           valid,
  output logic                           hit,
  output logic                           full,
  output logic [3*COORD_BITS+6:0]        num,
  output logic [3*COORD_BITS+6:0]        den
);
  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D + 1;
  localparam int W = D + P + 3;

  function automatic logic signed [W-1:0] dot(input logic signed [D-1:0] u0, u1, u2,
                                               input logic signed [P-1:0] v0, v1, v2);
    logic signed [D+P-1:0] m0, m1, m2;
    m0 = u0 * v0;
    m1 = u1 * v1;
    m2 = u2 * v2;
    return W'(m0) + W'(m1) + W'(m2);
  endfunction

  logic                valid1_r, valid2_r, hit_r, full_r;
  logic signed [W-1:0] d_r, t_r, v_r, w_r, num_r, den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= dot(qp_x, qp_y, qp_z, n_x, n_y, n_z);
      t_r <= dot(ap_x, ap_y, ap_z, n_x, n_y, n_z);
      v_r <= dot(ac_x, ac_y, ac_z, e_x, e_y, e_z);
      w_r <= -dot(ab_x, ab_y, ab_z, e_x, e_y, e_z);
      hit_r <= (d_r > 0) && (t_r >= 0) && (t_r <= d_r) && (v_r >= 0) && (v_r <= d_r)
               && (w_r >= 0) && (v_r + w_r <= d_r);
      full_r <= (t_r == d_r);
      num_r <= t_r;
      den_r <= d_r;
    end
  end

  assign valid = valid2_r;
  assign hit   = hit_r;
  assign full  = full_r;
  assign num   = num_r;
  assign den   = den_r;
endmodule

// ===== design/sti_div.sv =====
// Restoring fraction divider, one quotient bit per register stage.
// Depends on nothing beyond its parameters.
module sti_div #(
  parameter int COORD_BITS     = 20,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      in_hit,
  input  logic                      in_full,
  input  logic [3*COORD_BITS+6:0]   in_num,
  input  logic [3*COORD_BITS+6:0]   in_den,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic [TIME_FRAC_BITS:0]   out_hit_time
);
  localparam int W = 3 * COORD_BITS + 7;
  localparam int F = TIME_FRAC_BITS;

  logic                valid_r [F];
  logic                hit_r   [F];
  logic                full_r  [F];
  logic [W-1:0]        rem_r   [F];
  logic [W-1:0]        den_r   [F];
  logic [F-1:0]        q_r     [F];
  logic                ovalid_r, ohit_r;
  logic [F:0]          otime_r;

  for (genvar k = 0; k < F; k++) begin : g_stage
    logic           pv, ph, pf;
    logic [W-1:0]   prem, pden;
    logic [F-1:0]   pq;
    logic [W:0]     sh;
    if (k == 0) begin : g_first
      assign pv = in_valid; assign ph = in_hit; assign pf = in_full;
      assign prem = in_num; assign pden = in_den; assign pq = '0;
    end else begin : g_next
      assign pv = valid_r[k-1]; assign ph = hit_r[k-1]; assign pf = full_r[k-1];
      assign prem = rem_r[k-1]; assign pden = den_r[k-1]; assign pq = q_r[k-1];
    end
    assign sh = {prem, 1'b0};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hit_r[k]  <= ph;
        full_r[k] <= pf;
        den_r[k]  <= pden;
        if (sh >= {1'b0, pden}) begin
          rem_r[k] <= W'(sh - {1'b0, pden});
          q_r[k]   <= {pq[F-2:0], 1'b1};
        end else begin
          rem_r[k] <= W'(sh);
          q_r[k]   <= {pq[F-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (en) begin
      ovalid_r <= valid_r[F-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ohit_r <= hit_r[F-1];
      if (!hit_r[F-1]) begin
        otime_r <= '0;
      end else if (full_r[F-1]) begin
        otime_r <= {1'b1, {F{1'b0}}};
      end else begin
        otime_r <= {1'b0, q_r[F-1]};
      end
    end
  end

  assign out_valid    = ovalid_r;
  assign out_hit      = ohit_r;
  assign out_hit_time = otime_r;
endmodule

// ===== design/segment_triangle_intersect.sv =====
// Segment versus triangle intersection, top level.
// Depends on sti_pkg, sti_front, sti_dot and sti_div.
//
// One triangle word is taken per cycle unless the output stalls; its result word
// passes through sti_front, sti_dot and sti_div, whose divider resolves one bit
// of hit_time per pipeline stage. A stall on the output freezes the whole
// pipeline. The segment is held in six registers written through the cfg port;
// the user must write them only while the block is idle, unenforced by the block.
module segment_triangle_intersect #(
  parameter int COORD_BITS     = 20,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sti_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [COORD_BITS-1:0]               cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_vertex_a_x, in_vertex_a_y, in_vertex_a_z,
  input  logic signed [COORD_BITS-1:0]        in_vertex_b_x, in_vertex_b_y, in_vertex_b_z,
  input  logic signed [COORD_BITS-1:0]        in_vertex_c_x, in_vertex_c_y, in_vertex_c_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic [TIME_FRAC_BITS:0]             out_hit_time
);
  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D + 1;
  localparam int W = 3 * COORD_BITS + 7;

  logic signed [COORD_BITS-1:0] sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;
  logic                         en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      ex_r <= '0; ey_r <= '0; ez_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        sti_pkg::REG_START_X: sx_r <= cfg_wdata;
        sti_pkg::REG_START_Y: sy_r <= cfg_wdata;
        sti_pkg::REG_START_Z: sz_r <= cfg_wdata;
        sti_pkg::REG_END_X:   ex_r <= cfg_wdata;
        sti_pkg::REG_END_Y:   ey_r <= cfg_wdata;
        sti_pkg::REG_END_Z:   ez_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // qp and ap are recomputed here through two register stages, matching the front end.
  logic signed [D-1:0] qp1x_r, qp1y_r, qp1z_r, ap1x_r, ap1y_r, ap1z_r;
  logic signed [D-1:0] qp2x_r, qp2y_r, qp2z_r, ap2x_r, ap2y_r, ap2z_r;
  always_ff @(posedge clk) begin
    if (en) begin
      qp1x_r <= D'(sx_r) - D'(ex_r);
      qp1y_r <= D'(sy_r) - D'(ey_r);
      qp1z_r <= D'(sz_r) - D'(ez_r);
      ap1x_r <= D'(sx_r) - D'(in_vertex_a_x);
      ap1y_r <= D'(sy_r) - D'(in_vertex_a_y);
      ap1z_r <= D'(sz_r) - D'(in_vertex_a_z);
      qp2x_r <= qp1x_r; qp2y_r <= qp1y_r; qp2z_r <= qp1z_r;
      ap2x_r <= ap1x_r; ap2y_r <= ap1y_r; ap2z_r <= ap1z_r;
    end
  end

  logic                f_valid;
  logic signed [D-1:0] ab_x, ab_y, ab_z, ac_x, ac_y, ac_z;
  logic signed [P-1:0] n_x, n_y, n_z, e_x, e_y, e_z;

  sti_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .en,
    .in_valid (in_valid && en),
    .ax (in_vertex_a_x), .ay (in_vertex_a_y), .az (in_vertex_a_z),
    .bx (in_vertex_b_x), .by (in_vertex_b_y), .bz (in_vertex_b_z),
    .cx (in_vertex_c_x), .cy (in_vertex_c_y), .cz (in_vertex_c_z),
    .sx (sx_r), .sy (sy_r), .sz (sz_r), .ex (ex_r), .ey (ey_r), .ez (ez_r),
    .valid (f_valid),
    .ab_x, .ab_y, .ab_z, .ac_x, .ac_y, .ac_z,
    .n_x, .n_y, .n_z, .e_x, .e_y, .e_z
  );

  logic         d_valid, d_hit, d_full;
  logic [W-1:0] d_num, d_den;

  sti_dot #(.COORD_BITS(COORD_BITS)) u_dot (
    .clk, .rst_n, .en,
    .in_valid (f_valid),
    .ab_x, .ab_y, .ab_z, .ac_x, .ac_y, .ac_z,
    .qp_x (qp2x_r), .qp_y (qp2y_r), .qp_z (qp2z_r),
    .ap_x (ap2x_r), .ap_y (ap2y_r), .ap_z (ap2z_r),
    .n_x, .n_y, .n_z, .e_x, .e_y, .e_z,
    .valid (d_valid), .hit (d_hit), .full (d_full), .num (d_num), .den (d_den)
  );

  sti_div #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div (
    .clk, .rst_n, .en,
    .in_valid (d_valid), .in_hit (d_hit), .in_full (d_full),
    .in_num (d_num), .in_den (d_den),
    .out_valid, .out_hit, .out_hit_time
  );
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for segment_triangle_intersect: directed and random triangles
// under several segment settings, with random idling and stalls on both channels.
// Depends on sti_pkg and the segment_triangle_intersect RTL.
module tb_top;
  localparam int CB = 20;
  localparam int TB = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [sti_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 3'd6;
  localparam logic [sti_pkg::CFG_IDX_BITS-1:0] REG_TOP = 3'd7;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [127:0] wide_t;
  typedef wide_t vec_t [3];
  typedef struct {
    coord_t v [9];
  } triangle_t;
  typedef struct {
    logic          hit;
    logic [TB:0]   hit_time;
  } pierce_t;

  class pierce_scoreboard;
    coord_t  seg [6];
    pierce_t pending [$];
    int      mismatches;
    int      words_checked;
    int      hits_seen;

    function new();
      foreach (seg[i]) seg[i] = '0;
      mismatches = 0;
      words_checked = 0;
      hits_seen = 0;
    endfunction

    function void write_reg(logic [sti_pkg::CFG_IDX_BITS-1:0] idx, coord_t val);
      if (idx <= sti_pkg::REG_END_Z) seg[idx] = val;
    endfunction

    function void cross_prod(input vec_t u, input vec_t w, output vec_t r);
      r[0] = u[1] * w[2] - u[2] * w[1];
      r[1] = u[2] * w[0] - u[0] * w[2];
      r[2] = u[0] * w[1] - u[1] * w[0];
    endfunction

    function wide_t dot(vec_t u, vec_t w);
      return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
    endfunction

    function pierce_t pierce(triangle_t tr);
      vec_t ab, ac, qp, ap, n, ex;
      wide_t d, t, v, w;
      pierce_t r;
      r.hit = 1'b0;
      r.hit_time = '0;
      for (int i = 0; i < 3; i++) begin
        ab[i] = wide_t'(tr.v[3+i]) - wide_t'(tr.v[i]);
        ac[i] = wide_t'(tr.v[6+i]) - wide_t'(tr.v[i]);
        qp[i] = wide_t'(seg[i]) - wide_t'(seg[3+i]);
        ap[i] = wide_t'(seg[i]) - wide_t'(tr.v[i]);
      end
      cross_prod(ab, ac, n);
      d = dot(qp, n);
      if (d <= 0) return r;
      t = dot(ap, n);
      if (t < 0 || t > d) return r;
      cross_prod(qp, ap, ex);
      v = dot(ac, ex);
      if (v < 0 || v > d) return r;
      w = -dot(ab, ex);
      if (w < 0 || v + w > d) return r;
      r.hit = 1'b1;
      r.hit_time = (TB+1)'((t <<< TB) / d);
      return r;
    endfunction

    function void note_triangle(triangle_t tr);
      pending.push_back(pierce(tr));
    endfunction

    function void check_word(logic hit, logic [TB:0] hit_time);
      pierce_t want;
      words_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: hit=%0d hit_time=%0d", hit, hit_time);
        return;
      end
      want = pending.pop_front();
      if (want.hit) hits_seen++;
      if (hit !== want.hit || hit_time !== want.hit_time) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected hit=%0d hit_time=%0d, got hit=%0d hit_time=%0d",
                   want.hit, want.hit_time, hit, hit_time);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sti_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [CB-1:0] cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall, out_hit;
  coord_t in_f [9];
  logic [TB:0] out_hit_time;
  logic hold_req;
  int idle_cycles;
  int sent;
  int settings;
  pierce_scoreboard sb;

  segment_triangle_intersect u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_a_x(in_f[0]), .in_vertex_a_y(in_f[1]), .in_vertex_a_z(in_f[2]),
    .in_vertex_b_x(in_f[3]), .in_vertex_b_y(in_f[4]), .in_vertex_b_z(in_f[5]),
    .in_vertex_c_x(in_f[6]), .in_vertex_c_y(in_f[7]), .in_vertex_c_z(in_f[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_hit_time(out_hit_time)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_word(out_hit, out_hit_time);
    if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall stretches, and one long hold-off on request.
  initial begin
    int len;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
          out_stall <= 1'b0;
        end
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic coord_t clampc(longint x);
    if (x > 524287) return coord_t'(524287);
    if (x < -524288) return coord_t'(-524288);
    return coord_t'(x);
  endfunction

  task automatic send_triangle(triangle_t tr, int gap);
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_f[i] <= tr.v[i];
    do @(posedge clk); while (in_stall);
    sb.note_triangle(tr);
    sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_segment(coord_t s [6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= sti_pkg::CFG_IDX_BITS'(i);
      cfg_wdata <= s[i];
      @(posedge clk);
      sb.write_reg(sti_pkg::CFG_IDX_BITS'(i), s[i]);
    end
    cfg_we <= 1'b1;
    cfg_idx <= ($urandom_range(0, 1) != 0) ? REG_SPARE : REG_TOP;
    cfg_wdata <= CB'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic triangle_t make_tri(longint ax, longint ay, longint az, longint bx,
                                         longint by, longint bz, longint cx, longint cy,
                                         longint cz);
    triangle_t tr;
    tr.v[0] = clampc(ax); tr.v[1] = clampc(ay); tr.v[2] = clampc(az);
    tr.v[3] = clampc(bx); tr.v[4] = clampc(by); tr.v[5] = clampc(bz);
    tr.v[6] = clampc(cx); tr.v[7] = clampc(cy); tr.v[8] = clampc(cz);
    return tr;
  endfunction

  // A triangle whose centroid lies on the segment, so that about half of them face it.
  function automatic triangle_t aimed_triangle();
    triangle_t tr;
    longint p [3];
    longint o1 [3];
    longint o2 [3];
    longint f, r;
    f = $urandom_range(0, 65536);
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 60000);
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'(sb.seg[i]) + (longint'(sb.seg[3+i]) - longint'(sb.seg[i])) * f / 65536;
      o1[i] = longint'($urandom_range(0, 2 * r)) - r;
      o2[i] = longint'($urandom_range(0, 2 * r)) - r;
    end
    tr = make_tri(p[0] + o1[0], p[1] + o1[1], p[2] + o1[2],
                  p[0] + o2[0], p[1] + o2[1], p[2] + o2[2],
                  p[0] - o1[0] - o2[0], p[1] - o1[1] - o2[1], p[2] - o1[2] - o2[2]);
    if ($urandom_range(0, 1) != 0) begin
      for (int i = 0; i < 3; i++) begin
        tr.v[3+i] = tr.v[6+i];
        tr.v[6+i] = clampc(p[i] + o2[i]);
      end
    end
    return tr;
  endfunction

  task automatic random_phase(int count, bit quiet);
    triangle_t tr;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        tr = aimed_triangle();
      end else begin
        for (int i = 0; i < 9; i++)
          tr.v[i] = (k == 9) ? coord_t'($urandom_range(0, 4000) - 2000) : coord_t'($urandom);
      end
      send_triangle(tr, quiet ? 0 : pick_gap());
    end
    drain();
  endtask

  initial begin
    coord_t seg [6];
    sb = new();
    hold_req = 1'b0;
    idle_cycles = 0;
    sent = 0;
    settings = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    for (int i = 0; i < 9; i++) in_f[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Segment still at reset: every triangle is degenerate against it.
    send_triangle(make_tri(-800, -800, 0, 800, -800, 0, 0, 800, 0), 0);
    send_triangle(make_tri(-524288, -524288, -524288, 524287, 524287, 524287,
                           524287, -524288, 524287), 2);
    drain();

    seg = '{0, 0, 1600, 0, 0, -1600};
    set_segment(seg);
    send_triangle(make_tri(-800, -800, 0, 800, -800, 0, 0, 800, 0), 0);
    send_triangle(make_tri(-800, -800, 0, 0, 800, 0, 800, -800, 0), 0);
    send_triangle(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5), 1);
    send_triangle(make_tri(-800, -800, 1600, 800, -800, 1600, 0, 800, 1600), 0);
    send_triangle(make_tri(-800, -800, -1600, 800, -800, -1600, 0, 800, -1600), 0);
    send_triangle(make_tri(-800, -800, -2000, 800, -800, -2000, 0, 800, -2000), 0);
    send_triangle(make_tri(4200, -800, 0, 5800, -800, 0, 5000, 800, 0), 3);
    send_triangle(make_tri(0, 0, 0, 800, 0, 0, 0, 800, 0), 0);
    send_triangle(make_tri(-800, -800, 100, 800, -800, -100, 0, 800, 0), 0);
    send_triangle(make_tri(0, 0, 5, 0, 0, 5, 0, 0, 5), 0);
    send_triangle(make_tri(-524288, -524288, 0, 524287, -524288, 0, 0, 524287, 0), 0);
    send_triangle(make_tri(524287, 524287, 524287, -524288, -524288, -524288,
                           524287, -524288, 0), 0);
    drain();

    seg = '{-524288, -524288, -524288, 524287, 524287, 524287};
    set_segment(seg);
    send_triangle(make_tri(524287, -524288, 0, -524288, 524287, 0, 0, 0, 524287), 0);
    send_triangle(make_tri(524287, -524288, 0, 0, 0, 524287, -524288, 524287, 0), 0);
    send_triangle(make_tri(-524288, -524288, -524288, 524287, -524288, 0,
                           0, 524287, -524288), 0);
    random_phase(70, 1'b0);

    seg = '{524287, 0, -524288, -524288, 0, 524287};
    set_segment(seg);
    hold_req = 1'b1;
    random_phase(80, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 6; i++)
        seg[i] = (ph == 3) ? coord_t'($urandom) : coord_t'($urandom_range(0, 400000) - 200000);
      set_segment(seg);
      random_phase(70, ph == 1);
    end

    repeat (40) @(posedge clk);
    $display("Sent %0d triangles over %0d segment settings;", sent, settings);
    $display("%0d result words checked, %0d hits.", sb.words_checked, sb.hits_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/sti_pkg.sv
design/sti_front.sv
design/sti_dot.sv
design/sti_div.sv
design/segment_triangle_intersect.sv
tb/tb_top.sv
